// File: sv/gtps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the GEMM tile plan sequencer.
// Used by gtps_ctrl, gtps_dp and gemm_tile_plan_sequencer; depends on nothing.

package gtps_pkg;

    // Result status codes.
    localparam logic [1:0] ST_TILE     = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Default tiling.
    localparam int TILE_M_DEF    = 16;
    localparam int TILE_N_DEF    = 16;
    localparam int TILE_K_DEF    = 16;
    localparam int MAX_TILES_DEF = 64;

    // Field widths.
    localparam int DIM_W   = 16;
    localparam int COUNT_W = 5;
    localparam int IDX_W   = 6;
    localparam int STAT_W  = 2;

    // Tile-count search: counts reach at most 64, running edges at most 64 times the tile size.
    localparam int CNT_W   = 7;
    localparam int ACC_W   = 17;
    localparam int PROD1_W = 2 * CNT_W;
    localparam int PROD2_W = 3 * CNT_W;

    typedef struct packed {
        logic              capture;
        logic              count_step;
        logic              mul_first;
        logic              mul_second;
        logic              load_tile;
        logic              load_flag;
        logic [STAT_W-1:0] flag_status;
    } gtps_cmd_t;

    typedef struct packed {
        logic any_zero;
        logic count_done;
        logic too_many;
        logic slot_free;
        logic walk_last;
    } gtps_sts_t;

endpackage

// File: sv/gtps_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine of the GEMM tile plan sequencer.
// Depends on gtps_pkg for the command and status structs and status codes.

module gtps_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gtps_pkg::gtps_sts_t sts,
    output gtps_pkg::gtps_cmd_t cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_MUL1   = 3'd3;
    localparam logic [2:0] S_MUL2   = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;
    localparam logic [2:0] S_WALK   = 3'd6;
    localparam logic [2:0] S_FLAG   = 3'd7;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [gtps_pkg::STAT_W-1:0] flag_reg;
    logic [gtps_pkg::STAT_W-1:0] flag_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        flag_next       = flag_reg;
        cmd             = '0;
        cmd.flag_status = flag_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.any_zero)
                begin
                    flag_next  = gtps_pkg::ST_EMPTY;
                    state_next = S_FLAG;
                end
                else
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                cmd.count_step = 1'b1;
                if (sts.count_done)
                begin
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul_first = 1'b1;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_second = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.too_many)
                begin
                    flag_next  = gtps_pkg::ST_OVERFLOW;
                    state_next = S_FLAG;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_tile = 1'b1;
                    if (sts.walk_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_FLAG:
            begin
                if (sts.slot_free)
                begin
                    cmd.load_flag = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            flag_reg  <= gtps_pkg::ST_TILE;
        end
        else
        begin
            state_reg <= state_next;
            flag_reg  <= flag_next;
        end
    end

endmodule

// File: sv/gtps_dp.sv
`timescale 1ns / 1ps
// Datapath of the GEMM tile plan sequencer: tile-count search, overflow check,
// tile walk counters and the output register. Depends on gtps_pkg.

module gtps_dp
#(
    parameter int TILE_M    = gtps_pkg::TILE_M_DEF,
    parameter int TILE_N    = gtps_pkg::TILE_N_DEF,
    parameter int TILE_K    = gtps_pkg::TILE_K_DEF,
    parameter int MAX_TILES = gtps_pkg::MAX_TILES_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [gtps_pkg::DIM_W-1:0]           rows_m,
    input  logic [gtps_pkg::DIM_W-1:0]           cols_n,
    input  logic [gtps_pkg::DIM_W-1:0]           depth_k,
    input  gtps_pkg::gtps_cmd_t                  cmd,
    output gtps_pkg::gtps_sts_t                  sts,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [gtps_pkg::STAT_W-1:0]          status,
    output logic [gtps_pkg::IDX_W-1:0]           tile_index,
    output logic [gtps_pkg::DIM_W-1:0]           row_start,
    output logic [gtps_pkg::COUNT_W-1:0]         row_count,
    output logic [gtps_pkg::DIM_W-1:0]           col_start,
    output logic [gtps_pkg::COUNT_W-1:0]         col_count,
    output logic [gtps_pkg::DIM_W-1:0]           depth_start,
    output logic [gtps_pkg::COUNT_W-1:0]         depth_count,
    output logic                                 first_depth,
    output logic                                 last_depth,
    output logic                                 last
);

    localparam int ACC_W   = gtps_pkg::ACC_W;
    localparam int CNT_W   = gtps_pkg::CNT_W;
    localparam int DIM_W   = gtps_pkg::DIM_W;
    localparam int COUNT_W = gtps_pkg::COUNT_W;
    localparam int IDX_W   = gtps_pkg::IDX_W;
    localparam int STAT_W  = gtps_pkg::STAT_W;

    // Dimension 0 is M, 1 is N, 2 is K.
    logic [2:0][ACC_W-1:0]   tile_acc;
    logic [2:0][DIM_W-1:0]   dim_reg;
    logic [2:0][ACC_W-1:0]   acc_reg;
    logic [2:0][ACC_W-1:0]   acc_next;
    logic [2:0][CNT_W-1:0]   cnt_reg;
    logic [2:0][CNT_W-1:0]   cnt_next;
    logic [2:0]              done_reg;
    logic [2:0]              done_next;
    logic [2:0]              big_reg;
    logic [2:0]              big_next;
    logic [gtps_pkg::PROD1_W-1:0] prod1_reg;
    logic [gtps_pkg::PROD2_W-1:0] prod2_reg;

    logic [2:0][DIM_W-1:0]   start_reg;
    logic [2:0][DIM_W-1:0]   start_next;
    logic [2:0][DIM_W-1:0]   rest;
    logic [2:0]              fits;
    logic [2:0][COUNT_W-1:0] cnt_val;
    logic [IDX_W-1:0]        idx_reg;
    logic                    slot_free;

    logic                    out_valid_reg;
    logic [STAT_W-1:0]       status_reg;
    logic [IDX_W-1:0]        tile_index_reg;
    logic [DIM_W-1:0]        row_start_reg;
    logic [COUNT_W-1:0]      row_count_reg;
    logic [DIM_W-1:0]        col_start_reg;
    logic [COUNT_W-1:0]      col_count_reg;
    logic [DIM_W-1:0]        depth_start_reg;
    logic [COUNT_W-1:0]      depth_count_reg;
    logic                    first_depth_reg;
    logic                    last_depth_reg;
    logic                    last_reg;

    assign tile_acc = {ACC_W'(TILE_K), ACC_W'(TILE_N), ACC_W'(TILE_M)};

    // Tile counts are found by stepping a running tile edge past each size,
    // all three sizes in parallel, giving up once a count reaches MAX_TILES.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_next[i]  = acc_reg[i];
            cnt_next[i]  = cnt_reg[i];
            done_next[i] = done_reg[i];
            big_next[i]  = big_reg[i];
            if (cmd.capture)
            begin
                acc_next[i]  = tile_acc[i];
                cnt_next[i]  = CNT_W'(1);
                done_next[i] = 1'b0;
                big_next[i]  = 1'b0;
            end
            else if (cmd.count_step && !done_reg[i])
            begin
                if (acc_reg[i] >= {1'b0, dim_reg[i]})
                begin
                    done_next[i] = 1'b1;
                end
                else if (cnt_reg[i] == CNT_W'(MAX_TILES))
                begin
                    done_next[i] = 1'b1;
                    big_next[i]  = 1'b1;
                end
                else
                begin
                    acc_next[i] = acc_reg[i] + tile_acc[i];
                    cnt_next[i] = cnt_reg[i] + CNT_W'(1);
                end
            end
        end
    end

    // Walk: a range is on its last tile when what remains fits in one tile.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rest[i]    = dim_reg[i] - start_reg[i];
            fits[i]    = ({1'b0, rest[i]} <= tile_acc[i]);
            cnt_val[i] = fits[i] ? rest[i][COUNT_W-1:0] : tile_acc[i][COUNT_W-1:0];
        end
    end

    always_comb
    begin
        start_next = start_reg;
        if (cmd.capture)
        begin
            start_next = '0;
        end
        else if (cmd.load_tile)
        begin
            start_next[2] = fits[2] ? '0 : start_reg[2] + tile_acc[2][DIM_W-1:0];
            if (fits[2])
            begin
                start_next[1] = fits[1] ? '0 : start_reg[1] + tile_acc[1][DIM_W-1:0];
                if (fits[1])
                begin
                    start_next[0] = start_reg[0] + tile_acc[0][DIM_W-1:0];
                end
            end
        end
    end

    assign slot_free = !out_valid_reg || out_ready;

    assign sts.any_zero   = (dim_reg[0] == '0) || (dim_reg[1] == '0) || (dim_reg[2] == '0);
    assign sts.count_done = &done_reg;
    assign sts.too_many   = (|big_reg) || (prod2_reg > gtps_pkg::PROD2_W'(MAX_TILES));
    assign sts.slot_free  = slot_free;
    assign sts.walk_last  = &fits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            done_reg      <= '0;
            big_reg       <= '0;
            start_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            big_reg   <= big_next;
            start_reg <= start_next;
            if (cmd.capture)
            begin
                idx_reg <= '0;
            end
            else if (cmd.load_tile)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.load_tile || cmd.load_flag)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            dim_reg <= {depth_k, cols_n, rows_m};
        end
        if (cmd.mul_first)
        begin
            prod1_reg <= gtps_pkg::PROD1_W'(cnt_reg[0]) * gtps_pkg::PROD1_W'(cnt_reg[1]);
        end
        if (cmd.mul_second)
        begin
            prod2_reg <= gtps_pkg::PROD2_W'(prod1_reg) * gtps_pkg::PROD2_W'(cnt_reg[2]);
        end
        if (cmd.load_tile)
        begin
            status_reg      <= gtps_pkg::ST_TILE;
            tile_index_reg  <= idx_reg;
            row_start_reg   <= start_reg[0];
            row_count_reg   <= cnt_val[0];
            col_start_reg   <= start_reg[1];
            col_count_reg   <= cnt_val[1];
            depth_start_reg <= start_reg[2];
            depth_count_reg <= cnt_val[2];
            first_depth_reg <= (start_reg[2] == '0);
            last_depth_reg  <= fits[2];
            last_reg        <= &fits;
        end
        else if (cmd.load_flag)
        begin
            status_reg      <= cmd.flag_status;
            tile_index_reg  <= '0;
            row_start_reg   <= '0;
            row_count_reg   <= '0;
            col_start_reg   <= '0;
            col_count_reg   <= '0;
            depth_start_reg <= '0;
            depth_count_reg <= '0;
            first_depth_reg <= 1'b0;
            last_depth_reg  <= 1'b0;
            last_reg        <= 1'b1;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign tile_index  = tile_index_reg;
    assign row_start   = row_start_reg;
    assign row_count   = row_count_reg;
    assign col_start   = col_start_reg;
    assign col_count   = col_count_reg;
    assign depth_start = depth_start_reg;
    assign depth_count = depth_count_reg;
    assign first_depth = first_depth_reg;
    assign last_depth  = last_depth_reg;
    assign last        = last_reg;

endmodule

// File: sv/gemm_tile_plan_sequencer.sv
`timescale 1ns / 1ps
// GEMM tile plan sequencer: turns one (M, N, K) request into a stream of
// tile descriptors. Top level; depends on gtps_pkg, gtps_ctrl and gtps_dp.
//
// Usage:
// The input channel (in_valid / in_ready) carries rows_m, cols_n and depth_k.
// The output channel (out_valid / out_ready) carries one tile descriptor per
// transfer, M outermost, then N, then K, and marks the final one with last.
// A request with a zero size gives one transfer with status empty; a request
// whose tile count exceeds MAX_TILES gives one transfer with status overflow.
// One request is handled at a time; in_ready is high only while idle.
// After a request is taken, the block finds the three tile counts by stepping
// a running edge per range (each per-range count stops at MAX_TILES), then
// multiplies the counts, M by N and then by K, and checks the product.
// Descriptors then follow one a cycle while the receiver takes them.
// When the receiver stalls, the output register holds its result and the walk
// pauses; nothing is lost. Reset empties the output register and returns the
// controller to idle.

module gemm_tile_plan_sequencer
#(
    parameter int TILE_M    = gtps_pkg::TILE_M_DEF,
    parameter int TILE_N    = gtps_pkg::TILE_N_DEF,
    parameter int TILE_K    = gtps_pkg::TILE_K_DEF,
    parameter int MAX_TILES = gtps_pkg::MAX_TILES_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gtps_pkg::DIM_W-1:0]    rows_m,
    input  logic [gtps_pkg::DIM_W-1:0]    cols_n,
    input  logic [gtps_pkg::DIM_W-1:0]    depth_k,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [gtps_pkg::STAT_W-1:0]   status,
    output logic [gtps_pkg::IDX_W-1:0]    tile_index,
    output logic [gtps_pkg::DIM_W-1:0]    row_start,
    output logic [gtps_pkg::COUNT_W-1:0]  row_count,
    output logic [gtps_pkg::DIM_W-1:0]    col_start,
    output logic [gtps_pkg::COUNT_W-1:0]  col_count,
    output logic [gtps_pkg::DIM_W-1:0]    depth_start,
    output logic [gtps_pkg::COUNT_W-1:0]  depth_count,
    output logic                          first_depth,
    output logic                          last_depth,
    output logic                          last
);

    gtps_pkg::gtps_cmd_t cmd;
    gtps_pkg::gtps_sts_t sts;

    gtps_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    gtps_dp
    #(
        .TILE_M    (TILE_M),
        .TILE_N    (TILE_N),
        .TILE_K    (TILE_K),
        .MAX_TILES (MAX_TILES)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rows_m      (rows_m),
        .cols_n      (cols_n),
        .depth_k     (depth_k),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .tile_index  (tile_index),
        .row_start   (row_start),
        .row_count   (row_count),
        .col_start   (col_start),
        .col_count   (col_count),
        .depth_start (depth_start),
        .depth_count (depth_count),
        .first_depth (first_depth),
        .last_depth  (last_depth),
        .last        (last)
    );

    // A flag result always closes its plan.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != gtps_pkg::ST_TILE) |-> last)
    else $error("flag result without last");

    // The plan can only end on the last K step of a tile.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == gtps_pkg::ST_TILE) && !last_depth |-> !last)
    else $error("plan ended before the last K step");

    // No request is taken while a plan is still being produced.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_tile && !sts.walk_last |-> !in_ready)
    else $error("input taken during a tile walk");

    // The first tile of a plan sits at the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == gtps_pkg::ST_TILE) && (tile_index == '0)
        |-> (row_start == '0) && (col_start == '0) && (depth_start == '0) && first_depth)
    else $error("first tile not at the origin");

    // Output status never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == gtps_pkg::ST_TILE) || (status == gtps_pkg::ST_EMPTY)
                      || (status == gtps_pkg::ST_OVERFLOW))
    else $error("unused status code");

endmodule
